// ----- hdl/integral_image_stream_assert.svh -----
// Assertion macros for the integral image stream block.
`ifndef INTEGRAL_IMAGE_STREAM_ASSERT_SVH
`define INTEGRAL_IMAGE_STREAM_ASSERT_SVH

// same-cycle implication
`define IIS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/iis_pkg.sv -----
// Shared constants and types for the integral image stream block.
package iis_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int CSUM_W     = 18;
  localparam int VAL_W      = 28;
  localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             row_first;
    logic             last;
  } pos_t;

endpackage

// ----- hdl/iis_col_ram.sv -----
// Column sum memory: one write port, one registered read port.
module iis_col_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/iis_pos_ctr.sv -----
// Frame size registers and raster position counters.
module iis_pos_ctr (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [iis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iis_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          adv,
  output iis_pkg::pos_t                 pos
);
  import iis_pkg::*;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic             last_col;
  logic             last_row;

  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = image_height;
    end
  end

  assign last_col = (DIM_W'(col) + DIM_W'(1)) >= w_eff;
  assign last_row = (DIM_W'(row) + DIM_W'(1)) >= h_eff;

  assign pos.col       = col;
  assign pos.row_first = (row == '0);
  assign pos.last      = last_col && last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_MAX;
      image_height <= HEIGHT_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (adv) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

// ----- hdl/integral_image_stream.sv -----
// Integral image stream top level: column sum read-modify-write and output register.
//
//  channel  | dir | fields
//  ---------+-----+-------------------------------------------
//  s_axis   | in  | tdata[7:0] pixel
//  m_axis   | out | tdata[27:0] integral_value, tlast frame_last
//  cfg      | in  | index 0 image_width, 1 image_height
//
// One pixel per clock while the output is not stalled; the RAM is read as a pixel is
// taken into s1, and the add, write back and output register load happen as s1 fires.
// A column read that meets the write of the same column in one cycle
// (width of one) takes the written sum from a bypass register.
// Reset clears counters, row sum and the pipeline; the column RAM is
// not cleared, row zero writes every entry before it is read.
// A stalled output holds the pipeline; s_axis_tready drops only then.
`include "integral_image_stream_assert.svh"
module integral_image_stream (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [iis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iis_pkg::DIM_W-1:0]       cfg_data,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [iis_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] pixel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [iis_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [27:0] integral_value, rest zero
  output logic                            m_axis_tlast
);
  import iis_pkg::*;

  pos_t              pos;
  logic              s_accept;
  logic              s1_fire;

  logic              s1_valid;
  logic [PIX_W-1:0]  s1_pix;
  pos_t              s1_pos;
  logic              s1_fwd;
  logic [CSUM_W-1:0] fwd_data;
  logic [CSUM_W-1:0] rd_data;
  logic [CSUM_W-1:0] csum;
  logic [CSUM_W-1:0] base;
  logic [VAL_W-1:0]  left;
  logic [VAL_W-1:0]  val;
  logic [VAL_W-1:0]  row_acc;

  logic              out_valid;
  logic [VAL_W-1:0]  out_val;
  logic              out_last;

  assign s1_fire       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_fire;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  iis_pos_ctr u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .adv       (s_accept),
    .pos       (pos)
  );

  iis_col_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (CSUM_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (s_accept),
    .rd_addr (pos.col),
    .rd_data (rd_data),
    .wr_en   (s1_fire),
    .wr_addr (s1_pos.col),
    .wr_data (csum)
  );

  always_comb begin
    base = s1_fwd ? fwd_data : rd_data;
    csum = s1_pos.row_first ? CSUM_W'(s1_pix) : base + CSUM_W'(s1_pix);
    left = (s1_pos.col == '0) ? '0 : row_acc;
    val  = left + VAL_W'(csum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pix <= s_axis_tdata[PIX_W-1:0];
      s1_pos <= pos;
      s1_fwd <= s1_fire && (s1_pos.col == pos.col);
    end
    if (s1_fire) begin
      fwd_data <= csum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc <= '0;
    end else if (s1_fire) begin
      row_acc <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_val  <= val;
      out_last <= s1_pos.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'(out_val);
  assign m_axis_tlast  = out_last;

  `IIS_ASSERT_NEXT(a_fire_fills_out, s1_fire, out_valid, "result lost after compute")
  `IIS_ASSERT_NOW(a_stall_blocks_in, s1_valid && !s1_fire, !s_axis_tready, "pixel in stall")
  `IIS_ASSERT_NEXT(a_frame_wrap, s_accept && pos.last, pos.col == '0 && pos.row_first, "no wrap")

endmodule

// ----- test/integral_image_stream_tb.sv -----
// Self-checking testbench for integral_image_stream: pixel frames against a summed-area predictor.
module integral_image_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iis_pkg::*;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int IDLE_PCT       = 34;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_PIXELS  = 300;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } sat_word_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [DIM_W-1:0]       cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] pixel
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [27:0] integral_value, rest zero
  logic                   m_axis_tlast;

  integral_image_stream u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // summed-area predictor state
  logic [DIM_W-1:0]  width_reg;
  logic [DIM_W-1:0]  height_reg;
  logic [CSUM_W-1:0] col_sum [MAX_WIDTH];
  logic [VAL_W-1:0]  row_sum;
  int unsigned       col_pos;
  int unsigned       row_pos;
  sat_word_t         due_sums [$];

  bit          steady      = 1'b0;
  int          hold_cycles = 0;
  int          mismatches  = 0;
  int unsigned cycles      = 0;
  int unsigned pixels_sent = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  function automatic void advance_sum_table(input logic [PIX_W-1:0] pix);
    int unsigned       w;
    int unsigned       h;
    int unsigned       c;
    int unsigned       r;
    logic [CSUM_W-1:0] csum;
    logic [VAL_W-1:0]  val;
    sat_word_t         word;
    bit                last_col;
    bit                last_row;
    w = eff_dim(width_reg, MAX_WIDTH);
    h = eff_dim(height_reg, MAX_HEIGHT);
    c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    r = row_pos;
    csum = (r == 0) ? CSUM_W'(pix) : col_sum[c] + CSUM_W'(pix);
    col_sum[c] = csum;
    val = ((c == 0) ? VAL_W'(0) : row_sum) + VAL_W'(csum);
    row_sum = val;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);
    word.value = val;
    word.last  = last_col && last_row;
    due_sums = {due_sums, word};
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(pix);
    do @(posedge clk); while (!s_axis_tready);
    advance_sum_table(pix);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int n);
    repeat (n) send_pixel(pick_pixel());
  endtask

  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) send_pixel(pick_pixel());
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (due_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers, back to back; caller makes sure the block is idle
  task automatic write_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    width_reg = w;
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    height_reg = h;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_dims();
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd128);
  endtask

  // shrink width while at column 4 of row 0, then cut height below the current row
  task automatic test_mid_frame_change();
    wait_drain();
    write_dims(11'd3, 11'd2);
    finish_frame();
    wait_drain();
    write_dims(11'd2, 11'd4);
    send_pixels(4);
    wait_drain();
    write_dims(11'd2, 11'd1);
    finish_frame();
  endtask

  task automatic test_dim_limits();
    wait_drain();
    write_dims(11'd0, 11'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd170);
    wait_drain();
    write_dims(11'd1, 11'd3);
    repeat (3) send_pixel(8'd255);
  endtask

  task automatic test_pixel_extremes();
    wait_drain();
    write_dims(11'd2, 11'd2);
    repeat (4) send_pixel(8'd255);
  endtask

  // sizes above the maximum, then cut down mid-frame to close the frame early
  task automatic test_large_frames();
    wait_drain();
    write_dims(11'd2047, 11'd2047);
    send_pixels(40);
    wait_drain();
    write_dims(11'd4, 11'd3);
    finish_frame();
    wait_drain();
    write_dims(11'd1, 11'd2047);
    send_pixels(20);
    wait_drain();
    write_dims(11'd1, 11'd0);
    finish_frame();
  endtask

  task automatic test_backpressure();
    wait_drain();
    write_dims(11'd8, 11'd5);
    hold_cycles = 150;
    steady = 1'b1;
    send_pixels(20);
    steady = 1'b0;
    wait_drain();
    finish_frame();
  endtask

  task automatic test_steady_stream();
    int start;
    start = pixels_sent;
    steady = 1'b1;
    while (pixels_sent - start < 80) begin
      wait_drain();
      write_dims(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 6)));
      send_pixels(1);
      finish_frame();
    end
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int               start;
    int unsigned      total;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      w = ($urandom_range(19) == 0) ? '0 : DIM_W'($urandom_range(1, 40));
      h = ($urandom_range(19) == 0) ? '0 : DIM_W'($urandom_range(1, 12));
      wait_drain();
      write_dims(w, h);
      total = eff_dim(w, MAX_WIDTH) * eff_dim(h, MAX_HEIGHT);
      if ($urandom_range(5) == 0) begin
        // width may only shrink mid-frame so no unwritten column is read
        send_pixels($urandom_range(0, total - 1));
        wait_drain();
        write_dims(DIM_W'($urandom_range(1, eff_dim(w, MAX_WIDTH))),
                   DIM_W'($urandom_range(0, 12)));
        finish_frame();
      end else begin
        send_pixels(total);
      end
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : check_sums
    sat_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_sums.size() == 0) begin
        flag_mismatch($sformatf("unexpected word tdata=%0d tlast=%0b",
                                m_axis_tdata, m_axis_tlast));
      end else begin
        want = due_sums.pop_front();
        if (m_axis_tdata !== OUT_TDATA_W'(want.value))
          flag_mismatch($sformatf("integral_value expected %0d got %0d",
                                  want.value, m_axis_tdata));
        if (m_axis_tlast !== want.last)
          flag_mismatch($sformatf("frame_last expected %0b got %0b",
                                  want.last, m_axis_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_IMAGE_WIDTH;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    width_reg     = WIDTH_MAX;
    height_reg    = HEIGHT_MAX;
    row_sum       = '0;
    col_pos       = 0;
    row_pos       = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_dims();
    test_mid_frame_change();
    test_dim_limits();
    test_pixel_extremes();
    test_large_frames();
    test_backpressure();
    test_steady_stream();
    test_random_frames();
    wait_drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
